// ===== hdl/bstk_pkg.sv =====
`timescale 1ns / 1ps
// bstk_pkg: shared types, codes and defaults for the bounded stack block
// depends on nothing; imported by bstk_ram and the top level
package bstk_pkg;

   localparam int DEPTH_DEF = 8;
   localparam int WORD_W    = 32;

   // operation codes
   localparam logic [1:0] OP_PUSH = 2'd0;
   localparam logic [1:0] OP_POP  = 2'd1;
   localparam logic [1:0] OP_DISP = 2'd2;
   localparam logic [1:0] OP_PAL  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] data_out;
      logic                     is_palindrome;
      logic                     last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_EMIT,
      S_PAL_RD,
      S_PAL_CMP,
      S_RESP
   } state_type;

endpackage

// ===== hdl/bstk_ram.sv =====
`timescale 1ns / 1ps
// bstk_ram: stack storage, one write port and two registered read ports
// depends on bstk_pkg for the word width and the default depth
module bstk_ram #(
   parameter int DEPTH = bstk_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [bstk_pkg::WORD_W-1:0]   wr_data,
   input  logic [AW-1:0]                 rd_addr_a,
   input  logic [AW-1:0]                 rd_addr_b,
   output logic [bstk_pkg::WORD_W-1:0]   rd_data_a,
   output logic [bstk_pkg::WORD_W-1:0]   rd_data_b
);
   import bstk_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_a_ff;
   logic [WORD_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/bounded_stack_with_palindrome_check_top.sv =====
`timescale 1ns / 1ps
// bounded LIFO stack of signed words with pop, display and palindrome check
// requests enter on req_valid / req_stall, results leave on rsp_valid / rsp_stall.
// each request is an operation and a push value; each result carries status,
// data_out, is_palindrome and last, which marks the final result of a request.
// one request is worked at a time: req_stall is high from acceptance until the
// final result has been loaded into the output register.
// push reaches the output register through S_RESP; pop through S_RD and S_EMIT.
// display of n words: one read step and one emit step per word.
// palindrome of n words: pairs are read (S_PAL_RD) and compared (S_PAL_CMP)
// from both ends inward, stopping at a mismatch; an empty stack goes to S_RESP.
// the output register frees as the previous result is taken, so a waiting
// result does not block acceptance once the request is finished.
// a stalled receiver holds rsp_data and rsp_valid and pauses display streaming.
// reset (synchronous) empties the stack and drops any pending result; storage
// is not cleared since an entry is only read below the fill count.
// depends on bstk_pkg and bstk_ram
module bounded_stack_with_palindrome_check_top #(
   parameter int DEPTH = bstk_pkg::DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bstk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bstk_pkg::rsp_type rsp_data
);
   import bstk_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]  op_ff, op_in;
   logic [AW-1:0] addr_a_ff, addr_a_in;
   logic [AW-1:0] addr_b_ff, addr_b_in;
   rsp_type     res_ff, res_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   logic              wr_en;
   logic [WORD_W-1:0] rd_a;
   logic [WORD_W-1:0] rd_b;
   logic [CW-1:0]     count_m1;
   logic              full;
   logic              empty;
   logic              out_free;
   logic              load_out;
   logic              emit_last;

   bstk_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_data   (req_data.push_value),
      .rd_addr_a (addr_a_ff),
      .rd_addr_b (addr_b_ff),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign count_m1  = count_ff - CW'(1);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign emit_last = (addr_a_ff == '0) || (op_ff == OP_POP);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      op_in     = op_ff;
      addr_a_in = addr_a_ff;
      addr_b_in = addr_b_ff;
      res_in    = res_ff;
      out_in    = res_ff;
      wr_en     = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in                = req_data.operation;
               res_in.status        = ST_OK;
               res_in.data_out      = '0;
               res_in.is_palindrome = 1'b0;
               res_in.last          = 1'b1;
               state_in             = S_RESP;
               unique case (req_data.operation)
                  OP_PUSH: begin
                     if (full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        count_in  = count_m1;
                        addr_a_in = count_m1[AW-1:0];
                        state_in  = S_RD;
                     end
                  end
                  OP_DISP: begin
                     if (empty) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        addr_a_in = count_m1[AW-1:0];
                        state_in  = S_RD;
                     end
                  end
                  OP_PAL: begin
                     if (empty) begin
                        res_in.status        = ST_EMPTY;
                        res_in.is_palindrome = 1'b1;
                     end else begin
                        addr_a_in = '0;
                        addr_b_in = count_m1[AW-1:0];
                        state_in  = S_PAL_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               load_out             = 1'b1;
               out_in.status        = ST_OK;
               out_in.data_out      = rd_a;
               out_in.is_palindrome = 1'b0;
               out_in.last          = emit_last;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  addr_a_in = addr_a_ff - AW'(1);
                  state_in  = S_RD;
               end
            end
         end
         S_PAL_RD: begin
            state_in = S_PAL_CMP;
         end
         S_PAL_CMP: begin
            if (rd_a != rd_b) begin
               res_in.is_palindrome = 1'b0;
               state_in             = S_RESP;
            end else if ((addr_a_ff >= addr_b_ff) || (addr_a_ff + AW'(1) == addr_b_ff)) begin
               res_in.is_palindrome = 1'b1;
               state_in             = S_RESP;
            end else begin
               addr_a_in = addr_a_ff + AW'(1);
               addr_b_in = addr_b_ff - AW'(1);
               state_in  = S_PAL_RD;
            end
         end
         S_RESP: begin
            if (out_free) begin
               load_out = 1'b1;
               out_in   = res_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      res_ff    <= res_in;
      if (load_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_count_busy_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> (count_ff == $past(count_ff)))
      else $error("fill count moved while a request was in progress");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.operation == OP_PUSH && !full)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not grow the stack");

   a_pal_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAL_CMP) |-> (addr_a_ff <= addr_b_ff))
      else $error("palindrome pointers crossed");

   a_idle_last : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && state_ff == S_IDLE) |-> out_ff.last)
      else $error("pending result in idle is not the final one");
`endif

endmodule
